// File: sv/exg_pkg.sv
// Shared types, constants and scan tables for the Exp-Golomb coefficient decoder.
`timescale 1ns / 1ps

package exg_pkg;

    // Defaults handed to the top level parameters
    localparam int MAX_PREFIX_ZEROS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF      = 4;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int MODE_W      = 2;
    localparam int SCALE_W     = 8;
    localparam int QTAB_W      = 64;
    localparam int BLOCK_CNT_W = 13;
    localparam int BLOCK_NUM_W = 12;
    localparam int POS_W       = 4;
    localparam int COEF_W      = 41;

    localparam logic [COEF_W-1:0] COEF_LIMIT = {1'b0, {(COEF_W-1){1'b1}}};

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEQUANT_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZIGZAG_ORDER     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUANT_SCALE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_QUANT_TABLE_LOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_QUANT_TABLE_HIGH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_PER_FRAME = 3'd5;

    // Dequantisation modes
    localparam logic [MODE_W-1:0] DQ_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] DQ_TABLE  = 2'd1;
    localparam logic [MODE_W-1:0] DQ_SCALED = 2'd2;

    // Reset values of the configuration registers
    localparam logic [MODE_W-1:0]      DEQUANT_MODE_RST     = DQ_SCALED;
    localparam logic                   ZIGZAG_ORDER_RST     = 1'b1;
    localparam logic [SCALE_W-1:0]     QUANT_SCALE_RST      = 8'd1;
    localparam logic [BLOCK_CNT_W-1:0] BLOCKS_PER_FRAME_RST = 13'd1152;

    // Per-code side information travelling from front to back
    typedef struct packed {
        logic [POS_W-1:0]       scan;
        logic [BLOCK_NUM_W-1:0] block;
        logic                   block_end;
        logic                   last;
    } exg_tag_t;

    localparam int TAG_W = $bits(exg_tag_t);

    // Zigzag scan index to row-major raster position
    function automatic logic [POS_W-1:0] zz_raster(input logic [POS_W-1:0] k);
        logic [POS_W-1:0] r;
        unique case (k)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd1;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd8;
            4'd4:    r = 4'd5;
            4'd5:    r = 4'd2;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd6;
            4'd8:    r = 4'd9;
            4'd9:    r = 4'd12;
            4'd10:   r = 4'd13;
            4'd11:   r = 4'd10;
            4'd12:   r = 4'd7;
            4'd13:   r = 4'd11;
            4'd14:   r = 4'd14;
            default: r = 4'd15;
        endcase
        return r;
    endfunction

endpackage

// File: sv/exg_queue.sv
// Small register FIFO between the bit parser and the dequantiser.
`timescale 1ns / 1ps

module exg_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/exg_front.sv
// Bit parser: walks each byte one bit a cycle unless stalled by a full queue, finds codes and tags them with position.
`timescale 1ns / 1ps

module exg_front #(
    parameter int MAX_PREFIX_ZEROS = exg_pkg::MAX_PREFIX_ZEROS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [exg_pkg::BYTE_W-1:0]                stream_byte,
    input  logic                                      final_byte,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [exg_pkg::BLOCK_CNT_W-1:0]           blocks_per_frame,
    input  logic                                      q_full,
    output logic                                      q_push,
    output logic [MAX_PREFIX_ZEROS+exg_pkg::TAG_W:0]  q_data
);
    import exg_pkg::*;

    localparam int ZC_W  = $clog2(MAX_PREFIX_ZEROS + 2);
    localparam int CN_W  = MAX_PREFIX_ZEROS + 1;
    localparam int SUF_W = MAX_PREFIX_ZEROS;
    localparam logic [ZC_W-1:0] ZC_MAX = ZC_W'(MAX_PREFIX_ZEROS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BITS,
        S_FLUSH,
        S_DRAIN
    } state_t;

    state_t                 state_reg,      state_next;
    logic [BYTE_W-1:0]      byte_reg,       byte_next;
    logic                   final_reg,      final_next;
    logic [2:0]             bit_cnt_reg,    bit_cnt_next;
    logic [ZC_W-1:0]        zero_count_reg, zero_count_next;
    logic                   in_suffix_reg,  in_suffix_next;
    logic [ZC_W-1:0]        bits_left_reg,  bits_left_next;
    logic [SUF_W-1:0]       suffix_reg,     suffix_next;
    logic [POS_W-1:0]       code_pos_reg,   code_pos_next;
    logic [BLOCK_CNT_W-1:0] block_cnt_reg,  block_cnt_next;
    logic                   finished_reg,   finished_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [CN_W-1:0]        pend_cn_reg,    pend_cn_next;
    exg_tag_t               pend_tag_reg,   pend_tag_next;

    logic                   bit_v;
    logic [ZC_W-1:0]        zc_inc;
    logic [CN_W-1:0]        ones;
    logic [SUF_W-1:0]       suf_shift;
    logic [BLOCK_CNT_W-1:0] lim;
    logic [BLOCK_CNT_W-1:0] blk_inc;
    logic                   gen;
    logic                   adv;
    logic                   stall;
    logic [CN_W-1:0]        gen_cn;
    exg_tag_t               drain_tag;

    assign in_ready  = (state_reg == S_IDLE);
    assign bit_v     = byte_reg[BYTE_W-1];
    assign zc_inc    = zero_count_reg + 1'b1;
    assign ones      = (CN_W'(1) << zero_count_reg) - CN_W'(1);
    assign suf_shift = {suffix_reg[SUF_W-2:0], bit_v};
    assign lim       = (blocks_per_frame == '0) ? BLOCK_CNT_W'(1) : blocks_per_frame;
    assign blk_inc   = block_cnt_reg + 1'b1;

    always_comb
    begin
        drain_tag           = pend_tag_reg;
        drain_tag.last      = 1'b1;
        drain_tag.block_end = pend_tag_reg.block_end | final_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        final_next      = final_reg;
        bit_cnt_next    = bit_cnt_reg;
        zero_count_next = zero_count_reg;
        in_suffix_next  = in_suffix_reg;
        bits_left_next  = bits_left_reg;
        suffix_next     = suffix_reg;
        code_pos_next   = code_pos_reg;
        block_cnt_next  = block_cnt_reg;
        finished_next   = finished_reg;
        pend_valid_next = pend_valid_reg;
        pend_cn_next    = pend_cn_reg;
        pend_tag_next   = pend_tag_reg;
        q_push          = 1'b0;
        q_data          = {pend_cn_reg, pend_tag_reg};
        gen             = 1'b0;
        adv             = 1'b0;
        gen_cn          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next    = stream_byte;
                    final_next   = final_byte;
                    bit_cnt_next = '0;
                    state_next   = S_BITS;
                end
            end
            S_BITS:
            begin
                if (!finished_reg)
                begin
                    if (!in_suffix_reg)
                    begin
                        if (!bit_v)
                        begin
                            gen = (zc_inc > ZC_MAX);
                        end
                        else if (zero_count_reg == '0)
                        begin
                            gen = 1'b1;
                        end
                    end
                    else if (bits_left_reg == ZC_W'(1))
                    begin
                        gen    = 1'b1;
                        gen_cn = ones + CN_W'(suf_shift);
                    end
                    adv = gen;
                end
            end
            S_FLUSH:
            begin
                // pending prefix on a final byte: emit with its partial suffix dropped
                if (final_reg && !finished_reg && (in_suffix_reg || zero_count_reg != '0))
                begin
                    gen    = 1'b1;
                    gen_cn = ones;
                end
            end
            default:
            begin
            end
        endcase

        stall = gen && pend_valid_reg && q_full;

        unique case (state_reg)
            S_BITS:
            begin
                if (finished_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (!stall)
                begin
                    if (!in_suffix_reg)
                    begin
                        if (!bit_v)
                        begin
                            zero_count_next = (zc_inc > ZC_MAX) ? '0 : zc_inc;
                        end
                        else if (zero_count_reg != '0)
                        begin
                            in_suffix_next = 1'b1;
                            bits_left_next = zero_count_reg;
                            suffix_next    = '0;
                        end
                    end
                    else
                    begin
                        suffix_next    = suf_shift;
                        bits_left_next = bits_left_reg - 1'b1;
                        if (bits_left_reg == ZC_W'(1))
                        begin
                            in_suffix_next  = 1'b0;
                            zero_count_next = '0;
                            suffix_next     = '0;
                        end
                    end
                    byte_next    = {byte_reg[BYTE_W-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == 3'd7)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!stall)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // hold the last code until it can go out marked as end of byte
                if (!(pend_valid_reg && q_full))
                begin
                    if (pend_valid_reg)
                    begin
                        q_push          = 1'b1;
                        q_data          = {pend_cn_reg, drain_tag};
                        pend_valid_next = 1'b0;
                    end
                    if (final_reg)
                    begin
                        zero_count_next = '0;
                        in_suffix_next  = 1'b0;
                        bits_left_next  = '0;
                        suffix_next     = '0;
                        code_pos_next   = '0;
                        block_cnt_next  = '0;
                        finished_next   = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        if (gen && !stall)
        begin
            q_push                  = pend_valid_reg;
            pend_valid_next         = 1'b1;
            pend_cn_next            = gen_cn;
            pend_tag_next.scan      = code_pos_reg;
            pend_tag_next.block     = block_cnt_reg[BLOCK_NUM_W-1:0];
            pend_tag_next.block_end = (code_pos_reg == {POS_W{1'b1}});
            pend_tag_next.last      = 1'b0;
            if (adv)
            begin
                if (code_pos_reg == {POS_W{1'b1}})
                begin
                    code_pos_next  = '0;
                    block_cnt_next = blk_inc;
                    if (blk_inc >= lim)
                    begin
                        finished_next = 1'b1;
                    end
                end
                else
                begin
                    code_pos_next = code_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            final_reg      <= 1'b0;
            bit_cnt_reg    <= '0;
            zero_count_reg <= '0;
            in_suffix_reg  <= 1'b0;
            bits_left_reg  <= '0;
            suffix_reg     <= '0;
            code_pos_reg   <= '0;
            block_cnt_reg  <= '0;
            finished_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            final_reg      <= final_next;
            bit_cnt_reg    <= bit_cnt_next;
            zero_count_reg <= zero_count_next;
            in_suffix_reg  <= in_suffix_next;
            bits_left_reg  <= bits_left_next;
            suffix_reg     <= suffix_next;
            code_pos_reg   <= code_pos_next;
            block_cnt_reg  <= block_cnt_next;
            finished_reg   <= finished_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        pend_cn_reg  <= pend_cn_next;
        pend_tag_reg <= pend_tag_next;
    end

endmodule

// File: sv/exg_back.sv
// Dequantiser pipeline: signed mapping, table and scale products, saturation, output beat.
`timescale 1ns / 1ps

module exg_back #(
    parameter int MAX_PREFIX_ZEROS = exg_pkg::MAX_PREFIX_ZEROS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     q_empty,
    input  logic [MAX_PREFIX_ZEROS+exg_pkg::TAG_W:0] q_data,
    output logic                                     q_pop,
    input  logic [exg_pkg::MODE_W-1:0]               dequant_mode,
    input  logic                                     zigzag_order,
    input  logic [exg_pkg::SCALE_W-1:0]              quant_scale,
    input  logic [exg_pkg::QTAB_W-1:0]               quant_table_low,
    input  logic [exg_pkg::QTAB_W-1:0]               quant_table_high,
    output logic signed [exg_pkg::COEF_W-1:0]        coefficient,
    output logic [exg_pkg::POS_W-1:0]                raster_position,
    output logic [exg_pkg::POS_W-1:0]                scan_index,
    output logic [exg_pkg::BLOCK_NUM_W-1:0]          block_number,
    output logic                                     block_end,
    output logic                                     last_of_byte,
    output logic                                     out_valid,
    input  logic                                     out_ready
);
    import exg_pkg::*;

    localparam int CN_W   = MAX_PREFIX_ZEROS + 1;
    localparam int MAG_W  = MAX_PREFIX_ZEROS;
    localparam int P1_W   = MAG_W + 8;
    localparam int PROD_W = P1_W + SCALE_W;
    localparam int SAT_W  = (PROD_W > COEF_W) ? PROD_W : COEF_W;

    logic                   en;
    logic [CN_W-1:0]        head_cn;
    exg_tag_t               head_tag;
    logic [CN_W:0]          round_sum;
    logic [QTAB_W-1:0]      tab_sel;

    logic                   s1_valid_reg;
    logic [MAG_W-1:0]       s1_mag_reg;
    logic                   s1_neg_reg;
    logic [7:0]             s1_q_reg;
    exg_tag_t               s1_tag_reg;

    logic                   s2_valid_reg;
    logic [MAG_W-1:0]       s2_mag_reg;
    logic [P1_W-1:0]        s2_prod_reg;
    logic                   s2_neg_reg;
    exg_tag_t               s2_tag_reg;

    logic                   s3_valid_reg;
    logic [PROD_W-1:0]      s3_mag_reg;
    logic [PROD_W-1:0]      s3_mag_next;
    logic                   s3_neg_reg;
    exg_tag_t               s3_tag_reg;

    logic [SAT_W-1:0]       sat_in;
    logic [COEF_W-1:0]      sat_mag;

    logic                   out_valid_reg;
    logic [COEF_W-1:0]      coef_reg;
    logic [POS_W-1:0]       raster_reg;
    exg_tag_t               out_tag_reg;

    // whole pipeline advances together unless the output beat is held
    assign en       = !out_valid_reg || out_ready;
    assign q_pop    = en && !q_empty;
    assign head_cn  = q_data[MAX_PREFIX_ZEROS+TAG_W:TAG_W];
    assign head_tag = exg_tag_t'(q_data[TAG_W-1:0]);

    // odd code numbers map to negatives: magnitude is (cn + 1) / 2
    assign round_sum = {1'b0, head_cn} + (CN_W+1)'(head_cn[0]);
    assign tab_sel   = head_tag.scan[3] ? quant_table_high : quant_table_low;

    always_comb
    begin
        unique case (dequant_mode)
            DQ_NONE:   s3_mag_next = PROD_W'(s2_mag_reg);
            DQ_TABLE:  s3_mag_next = PROD_W'(s2_prod_reg);
            DQ_SCALED: s3_mag_next = PROD_W'(s2_prod_reg) * PROD_W'(quant_scale);
            default:   s3_mag_next = '0;
        endcase
    end

    assign sat_in  = SAT_W'(s3_mag_reg);
    assign sat_mag = (sat_in > SAT_W'(COEF_LIMIT)) ? COEF_LIMIT : sat_in[COEF_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg  <= round_sum[CN_W-1:1];
            s1_neg_reg  <= head_cn[0];
            s1_q_reg    <= tab_sel[head_tag.scan[2:0]*8 +: 8];
            s1_tag_reg  <= head_tag;

            s2_mag_reg  <= s1_mag_reg;
            s2_prod_reg <= P1_W'(s1_mag_reg) * P1_W'(s1_q_reg);
            s2_neg_reg  <= s1_neg_reg;
            s2_tag_reg  <= s1_tag_reg;

            s3_mag_reg  <= s3_mag_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_tag_reg  <= s2_tag_reg;

            coef_reg    <= s3_neg_reg ? (~sat_mag + 1'b1) : sat_mag;
            raster_reg  <= zigzag_order ? zz_raster(s3_tag_reg.scan) : s3_tag_reg.scan;
            out_tag_reg <= s3_tag_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign coefficient     = coef_reg;
    assign raster_position = raster_reg;
    assign scan_index      = out_tag_reg.scan;
    assign block_number    = out_tag_reg.block;
    assign block_end       = out_tag_reg.block_end;
    assign last_of_byte    = out_tag_reg.last;

endmodule

// File: sv/exp_golomb_coefficient_decoder.sv
// Path: the newest code of a byte waits in the parser for the next code or the end of the byte,
// then passes the queue and four register stages.
// Flow: a byte passes accept, its eight bits, flush and drain, the bits skipped once the frame
// has finished, and no new byte is taken before that; the front parses one bit a cycle while the
// queue has room for its codes, and the back takes one code a cycle while the output is not held.
// Reset: asynchronous active low; clears parser state, queue and pipeline valids, and
// returns the configuration registers to their documented defaults.
`timescale 1ns / 1ps

module exp_golomb_coefficient_decoder #(
    parameter int MAX_PREFIX_ZEROS = exg_pkg::MAX_PREFIX_ZEROS_DEF,
    parameter int QUEUE_DEPTH      = exg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [exg_pkg::BYTE_W-1:0]           stream_byte,
    input  logic                                 final_byte,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    output logic signed [exg_pkg::COEF_W-1:0]    coefficient,
    output logic [exg_pkg::POS_W-1:0]            raster_position,
    output logic [exg_pkg::POS_W-1:0]            scan_index,
    output logic [exg_pkg::BLOCK_NUM_W-1:0]      block_number,
    output logic                                 block_end,
    output logic                                 last_of_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 cfg_we,
    input  logic [exg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [exg_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import exg_pkg::*;

    localparam int EV_W = MAX_PREFIX_ZEROS + 1 + TAG_W;

    logic [MODE_W-1:0]      dequant_mode_reg;
    logic                   zigzag_order_reg;
    logic [SCALE_W-1:0]     quant_scale_reg;
    logic [QTAB_W-1:0]      quant_table_low_reg;
    logic [QTAB_W-1:0]      quant_table_high_reg;
    logic [BLOCK_CNT_W-1:0] blocks_per_frame_reg;

    logic            q_push;
    logic [EV_W-1:0] q_push_data;
    logic            q_full;
    logic            q_pop;
    logic [EV_W-1:0] q_pop_data;
    logic            q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dequant_mode_reg     <= DEQUANT_MODE_RST;
            zigzag_order_reg     <= ZIGZAG_ORDER_RST;
            quant_scale_reg      <= QUANT_SCALE_RST;
            quant_table_low_reg  <= '0;
            quant_table_high_reg <= '0;
            blocks_per_frame_reg <= BLOCKS_PER_FRAME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEQUANT_MODE:     dequant_mode_reg     <= cfg_data[MODE_W-1:0];
                REG_ZIGZAG_ORDER:     zigzag_order_reg     <= cfg_data[0];
                REG_QUANT_SCALE:      quant_scale_reg      <= cfg_data[SCALE_W-1:0];
                REG_QUANT_TABLE_LOW:  quant_table_low_reg  <= cfg_data;
                REG_QUANT_TABLE_HIGH: quant_table_high_reg <= cfg_data;
                REG_BLOCKS_PER_FRAME: blocks_per_frame_reg <= cfg_data[BLOCK_CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    exg_front #(
        .MAX_PREFIX_ZEROS (MAX_PREFIX_ZEROS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .stream_byte      (stream_byte),
        .final_byte       (final_byte),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .blocks_per_frame (blocks_per_frame_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_push_data)
    );

    exg_queue #(
        .W     (EV_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    exg_back #(
        .MAX_PREFIX_ZEROS (MAX_PREFIX_ZEROS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_data           (q_pop_data),
        .q_pop            (q_pop),
        .dequant_mode     (dequant_mode_reg),
        .zigzag_order     (zigzag_order_reg),
        .quant_scale      (quant_scale_reg),
        .quant_table_low  (quant_table_low_reg),
        .quant_table_high (quant_table_high_reg),
        .coefficient      (coefficient),
        .raster_position  (raster_position),
        .scan_index       (scan_index),
        .block_number     (block_number),
        .block_end        (block_end),
        .last_of_byte     (last_of_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready)
    );

endmodule

// File: tb/sv/exp_golomb_coefficient_decoder_test.sv
// Self-checking testbench for the Exp-Golomb coefficient decoder.
`timescale 1ns / 1ps

module exp_golomb_coefficient_decoder_test;
    import exg_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_WAIT  = 40;
    localparam int SHOW_LIMIT   = 10;
    localparam logic [MODE_W-1:0] DQ_UNUSED = 2'd3;
    localparam longint COEF_MAX = 64'h0000_00FF_FFFF_FFFF;
    localparam logic [POS_W-1:0] ZZ_RASTER [16] =
        '{4'd0, 4'd1, 4'd4, 4'd8, 4'd5, 4'd2, 4'd3, 4'd6,
          4'd9, 4'd12, 4'd13, 4'd10, 4'd7, 4'd11, 4'd14, 4'd15};

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [POS_W-1:0]         raster;
        logic [POS_W-1:0]         scan;
        logic [BLOCK_NUM_W-1:0]   block;
        logic                     blk_end;
        logic                     last;
    } coef_beat_t;

    typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [BYTE_W-1:0]        data_byte;
        logic                     fin;
        bit                       typed;
        coef_beat_t               want;
        logic [CFG_INDEX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic [BYTE_W-1:0]         stream_byte = '0;
    logic                      final_byte = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [COEF_W-1:0]  coefficient;
    logic [POS_W-1:0]          raster_position;
    logic [POS_W-1:0]          scan_index;
    logic [BLOCK_NUM_W-1:0]    block_number;
    logic                      block_end;
    logic                      last_of_byte;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    exp_golomb_coefficient_decoder DUT (
        .clk(clk),
        .rst_n(rst_n),
        .stream_byte(stream_byte),
        .final_byte(final_byte),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .coefficient(coefficient),
        .raster_position(raster_position),
        .scan_index(scan_index),
        .block_number(block_number),
        .block_end(block_end),
        .last_of_byte(last_of_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Predictor: registers
    logic [MODE_W-1:0]      dq_mode   = DEQUANT_MODE_RST;
    logic                   zz_on     = ZIGZAG_ORDER_RST;
    logic [SCALE_W-1:0]     q_scale   = QUANT_SCALE_RST;
    logic [QTAB_W-1:0]      q_tab_lo  = '0;
    logic [QTAB_W-1:0]      q_tab_hi  = '0;
    logic [BLOCK_CNT_W-1:0] blk_limit = BLOCKS_PER_FRAME_RST;

    // Predictor: parser state
    int zeros_seen, sfx_left, scan_pos, blocks_done;
    bit in_sfx, frame_done;
    longint sfx_val;

    coef_beat_t step_out[$];
    coef_beat_t coef_expected[$];
    stim_row_t  script[$];
    bit         bitq[$];

    bit quiet = 1'b0;
    bit dirty = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int n_bytes = 0;
    int n_frames = 0;
    int n_checked = 0;

    function automatic void clear_parser();
        zeros_seen = 0; sfx_left = 0; sfx_val = 0; in_sfx = 0;
        scan_pos = 0; blocks_done = 0; frame_done = 0;
    endfunction

    function automatic longint code_to_value(longint cn);
        if (cn[0])
            return -((cn + 1) >>> 1);
        return cn >>> 1;
    endfunction

    function automatic void emit_coef(longint val, bit flush);
        int k;
        longint q, c;
        coef_beat_t r;
        int lim;
        k = scan_pos & 15;
        q = longint'(((k < 8) ? q_tab_lo : q_tab_hi) >> ((k & 7) * 8)) & 64'hFF;
        case (dq_mode)
            DQ_NONE:   c = val;
            DQ_TABLE:  c = val * q;
            DQ_SCALED: c = val * q * longint'(q_scale);
            default:   c = 0;
        endcase
        if (c > COEF_MAX) c = COEF_MAX;
        if (c < -COEF_MAX) c = -COEF_MAX;
        r.coef    = c[COEF_W-1:0];
        r.raster  = zz_on ? ZZ_RASTER[k] : POS_W'(k);
        r.scan    = POS_W'(k);
        r.block   = BLOCK_NUM_W'(blocks_done);
        r.blk_end = (k == 15);
        r.last    = 1'b0;
        step_out.push_back(r);
        if (flush)
            return;
        if (k == 15) begin
            lim = (blk_limit == 0) ? 1 : int'(blk_limit);
            scan_pos = 0;
            blocks_done = (blocks_done + 1) & 13'h1FFF;
            if (blocks_done >= lim)
                frame_done = 1;
        end
        else begin
            scan_pos = k + 1;
        end
    endfunction

    // Work out the coefficients one stream byte releases
    function automatic void decode_byte(logic [BYTE_W-1:0] sb, logic fin);
        logic b;
        longint cn;
        step_out.delete();
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (frame_done)
                break;
            b = sb[i];
            if (!in_sfx) begin
                if (!b) begin
                    zeros_seen++;
                    if (zeros_seen > MAX_PREFIX_ZEROS_DEF) begin
                        zeros_seen = 0;
                        emit_coef(0, 0);
                    end
                end
                else if (zeros_seen == 0) begin
                    emit_coef(0, 0);
                end
                else begin
                    in_sfx = 1;
                    sfx_left = zeros_seen;
                    sfx_val = 0;
                end
            end
            else begin
                sfx_val = ((sfx_val << 1) | b) & 64'h7FFF_FFFF;
                sfx_left--;
                if (sfx_left == 0) begin
                    cn = ((longint'(1) << zeros_seen) - 1) + sfx_val;
                    in_sfx = 0;
                    zeros_seen = 0;
                    sfx_val = 0;
                    emit_coef(code_to_value(cn), 0);
                end
            end
        end
        if (fin) begin
            // flush a half-read code, dropping its partial suffix
            if (!frame_done && (in_sfx || zeros_seen > 0))
                emit_coef(code_to_value((longint'(1) << zeros_seen) - 1), 1);
            if (step_out.size() > 0)
                step_out[step_out.size()-1].blk_end = 1'b1;
            clear_parser();
        end
        if (step_out.size() > 0)
            step_out[step_out.size()-1].last = 1'b1;
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DEQUANT_MODE:     dq_mode   = val[MODE_W-1:0];
            REG_ZIGZAG_ORDER:     zz_on     = val[0];
            REG_QUANT_SCALE:      q_scale   = val[SCALE_W-1:0];
            REG_QUANT_TABLE_LOW:  q_tab_lo  = val;
            REG_QUANT_TABLE_HIGH: q_tab_hi  = val;
            REG_BLOCKS_PER_FRAME: blk_limit = val[BLOCK_CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void add_byte(logic [BYTE_W-1:0] sb, logic fin);
        stim_row_t r;
        r = '{ROW_BYTE, sb, fin, 1'b0, '0, '0, '0};
        script.push_back(r);
    endfunction

    // Single-coefficient byte with a hand-typed result at scan index 0 of block 0
    function automatic void add_typed(logic [BYTE_W-1:0] sb, logic fin, longint c,
                                      logic [POS_W-1:0] pos);
        stim_row_t r;
        coef_beat_t w;
        w = '{COEF_W'(c), pos, 4'd0, 12'd0, 1'b1, 1'b1};
        r = '{ROW_BYTE, sb, fin, 1'b1, w, '0, '0};
        script.push_back(r);
    endfunction

    function automatic void add_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '{ROW_REG, '0, 1'b0, 1'b0, '0, idx, val};
        script.push_back(r);
    endfunction

    // Hold valid until the beat is taken, then predict from the accepted byte
    task automatic send_byte(logic [BYTE_W-1:0] sb, logic fin, bit typed, coef_beat_t want);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        stream_byte <= sb;
        final_byte  <= fin;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        decode_byte(sb, fin);
        if (typed)
            coef_expected.push_back(want);
        else
            foreach (step_out[i]) coef_expected.push_back(step_out[i]);
        n_bytes++;
        if (fin) n_frames++;
        dirty = 1;
    endtask

    // Drain the pipeline before touching the registers
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (coef_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        dirty = 0;
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        if (dirty)
            settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        apply_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [MODE_W-1:0] mode, logic zz, logic [SCALE_W-1:0] scale,
                             logic [QTAB_W-1:0] lo, logic [QTAB_W-1:0] hi,
                             logic [BLOCK_CNT_W-1:0] blocks);
        write_reg(REG_DEQUANT_MODE, CFG_DATA_W'(mode));
        write_reg(REG_ZIGZAG_ORDER, CFG_DATA_W'(zz));
        write_reg(REG_QUANT_SCALE, CFG_DATA_W'(scale));
        write_reg(REG_QUANT_TABLE_LOW, lo);
        write_reg(REG_QUANT_TABLE_HIGH, hi);
        write_reg(REG_BLOCKS_PER_FRAME, CFG_DATA_W'(blocks));
    endtask

    // Append one Exp-Golomb code; a few overlong prefixes trip the long-prefix path
    function automatic void append_code();
        int len, pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)      len = $urandom_range(0, 3);
        else if (pick < 85) len = $urandom_range(4, 10);
        else if (pick < 97) len = $urandom_range(11, MAX_PREFIX_ZEROS_DEF);
        else                len = $urandom_range(MAX_PREFIX_ZEROS_DEF + 1, 30);
        repeat (len) bitq.push_back(1'b0);
        bitq.push_back(1'b1);
        repeat (len) bitq.push_back(1'($urandom_range(0, 1)));
    endfunction

    task automatic run_random(int n_items);
        int taken;
        logic [BYTE_W-1:0] sb;
        logic fin;
        taken = 0;
        while (taken < n_items) begin
            if (frame_done) begin
                // bytes are ignored here; restart soon
                sb  = BYTE_W'($urandom);
                fin = ($urandom_range(0, 2) == 0);
            end
            else begin
                taken++;
                if ($urandom_range(0, 9) == 0) begin
                    sb = BYTE_W'($urandom);
                end
                else begin
                    while (bitq.size() < BYTE_W) append_code();
                    for (int i = BYTE_W - 1; i >= 0; i--) sb[i] = bitq.pop_front();
                end
                fin = ($urandom_range(0, 29) == 0);
            end
            if (fin)
                bitq.delete();
            send_byte(sb, fin, 1'b0, '0);
        end
    endtask

    // Output stalls in random bursts
    always @(negedge clk) begin
        if (quiet) begin
            out_ready <= 1'b1;
        end
        else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    task automatic report(string what, coef_beat_t want, coef_beat_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("%0t %s: expected coef %0d pos %0d scan %0d blk %0d end %0b last %0b,",
                     $time, what, want.coef, want.raster, want.scan, want.block,
                     want.blk_end, want.last,
                     " got coef %0d pos %0d scan %0d blk %0d end %0b last %0b",
                     got.coef, got.raster, got.scan, got.block, got.blk_end, got.last);
    endtask

    always @(posedge clk) begin
        coef_beat_t got, want;
        if (rst_n && out_valid && out_ready) begin
            got = '{coefficient, raster_position, scan_index, block_number,
                    block_end, last_of_byte};
            if (coef_expected.size() == 0) begin
                report("unexpected beat", '0, got);
            end
            else begin
                want = coef_expected.pop_front();
                n_checked++;
                if (got !== want)
                    report("mismatch", want, got);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, coef_expected.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        clear_parser();

        // after reset the table is empty, so every coefficient is zero
        add_typed(8'h00, 1'b1, 0, 4'd0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_reg(REG_DEQUANT_MODE, CFG_DATA_W'(DQ_NONE));
        add_reg(REG_ZIGZAG_ORDER, '0);
        add_reg(REG_QUANT_SCALE, 64'd255);
        add_reg(REG_QUANT_TABLE_LOW, '1);
        add_reg(REG_QUANT_TABLE_HIGH, '1);
        add_reg(REG_BLOCKS_PER_FRAME, 64'd4096);
        // flushed prefixes, suffix dropped
        add_typed(8'h00, 1'b1, -128, 4'd0);
        add_typed(8'h01, 1'b1, -64, 4'd0);
        add_byte(8'h40, 1'b1);
        // long prefix emits zero on the 25th zero
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        add_reg(REG_DEQUANT_MODE, CFG_DATA_W'(DQ_SCALED));
        // largest positive then largest negative code at full scale
        for (int s = 0; s < 2; s++) begin
            add_byte(8'h00, 1'b0);
            add_byte(8'h00, 1'b0);
            add_byte(8'h00, 1'b0);
            add_byte(8'hFF, 1'b0);
            add_byte(8'hFF, 1'b0);
            add_byte(8'hFF, 1'b0);
            add_byte((s == 0) ? 8'h80 : 8'h00, 1'b1);
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_byte(script[i].data_byte, script[i].fin, script[i].typed, script[i].want);
        end

        configure(DQ_NONE, 1'b1, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                  13'd1);
        run_random(50);
        configure(DQ_TABLE, 1'b0, 8'd0, {$urandom, $urandom}, {$urandom, $urandom}, 13'd0);
        run_random(50);
        configure(DQ_SCALED, 1'b1, 8'd255, '1, '1, 13'd4096);
        run_random(70);
        configure(DQ_UNUSED, 1'($urandom), 8'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, 13'd3);
        run_random(40);
        configure(2'($urandom_range(0, 3)), 1'($urandom), 8'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, 13'($urandom_range(1, 6)));
        run_random(60);
        configure(DQ_SCALED, 1'($urandom), 8'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, 13'($urandom_range(2, 12)));
        quiet = 1;
        run_random(60);

        @(negedge clk);
        in_valid <= 1'b0;
        while (coef_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("Sent %0d stream bytes (%0d with the final flag) under nine register setups;",
                 n_bytes, n_frames);
        $display("checked %0d coefficients, %0d mismatched or unexpected", n_checked, mismatches);
        if (mismatches == 0 && coef_expected.size() == 0) begin
            $display("TEST PASSED");
        end
        else begin
            $display("%0d coefficients never arrived", coef_expected.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
sv/exg_pkg.sv
sv/exg_queue.sv
sv/exg_front.sv
sv/exg_back.sv
sv/exp_golomb_coefficient_decoder.sv
tb/sv/exp_golomb_coefficient_decoder_test.sv
